>>> hdl/sorted_min_priority_queue_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define SMPQ_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define SMPQ_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define SMPQ_ASSERT_NOW(label, cond, prop)
`define SMPQ_ASSERT_NEXT(label, cond, prop)
`endif

`endif

>>> hdl/smpq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted minimum priority queue package
// Shared widths, defaults, codes and the cell control type.
// ---------------------------------------------------------------------------
package smpq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int KEY_IN_W      = 32;
  localparam int TOP_W         = 32;
  localparam int COUNT_W       = 5;
  localparam int ERR_W         = 2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    logic push;
    logic pop;
  } smpq_ctl_t;

endpackage

>>> hdl/smpq_in_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Carries one push or pop item with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface smpq_in_if import smpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [KEY_IN_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

>>> hdl/smpq_out_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Carries the queue status item produced for every request.
// ---------------------------------------------------------------------------
interface smpq_out_if import smpq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOP_W-1:0]   top_key;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic [ERR_W-1:0]   error;

  modport source (output valid, output top_key, output count, output is_empty,
                  output error, input ready);
  modport sink (input valid, input top_key, input count, input is_empty,
                input error, output ready);
endinterface

>>> hdl/sorted_min_priority_queue.sv
// ---------------------------------------------------------------------------
// Sorted minimum priority queue
// Keys sit in ascending order along a row of cells; a push inserts ahead of
// equal keys and a pop shifts the row toward the head.
//
//   Channel  Direction  Payload
//   req      sink       cmd, key
//   rsp      source     top_key, count, is_empty, error
//
// One item is taken per cycle unless a response stalls; every cell compares and shifts
// in the same cycle, so the rate is set by the single compare-and-shift step of a cell.
// The response item appears in the cycle after its request is accepted.
// A stalled response holds req.ready low until it is taken.
// Reset clears the count, the error code and the response valid; cell keys need no reset.
// ---------------------------------------------------------------------------
module sorted_min_priority_queue import smpq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  smpq_in_if.sink    req,
  smpq_out_if.source rsp
);

`include "sorted_min_priority_queue_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  err_t                 err;
  err_t                 err_next;
  logic                 rsp_valid;
  logic                 accept;
  logic                 full;
  logic                 empty;
  smpq_ctl_t            ctl;
  logic [63:0]          push_ext;
  logic [KEY_WIDTH-1:0] push_key;
  logic [63:0]          top_ext;
  logic [KEY_WIDTH-1:0] keys [CAPACITY];
  logic                 lts  [CAPACITY];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CAP_CNT);
  assign empty     = (count == '0);
  assign push_ext  = 64'(req.key);
  assign push_key  = push_ext[KEY_WIDTH-1:0];

  always_comb begin
    ctl        = '0;
    count_next = count;
    err_next   = err;
    if (accept) begin
      err_next = ERR_OK;
      if (req.cmd == CMD_PUSH) begin
        if (full) begin
          err_next = ERR_FULL;
        end else begin
          ctl.push   = 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          err_next = ERR_EMPTY;
        end else begin
          ctl.pop    = 1'b1;
          count_next = count - 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic [KEY_WIDTH-1:0] prev_key;
    logic                 prev_lt;
    logic [KEY_WIDTH-1:0] next_key;

    if (i == 0) begin : g_head
      assign prev_key = push_key;
      assign prev_lt  = 1'b1;
    end else begin : g_body
      assign prev_key = keys[i-1];
      assign prev_lt  = lts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = keys[i];
    end else begin : g_link
      assign next_key = keys[i+1];
    end

    smpq_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .push_key(push_key),
      .prev_key(prev_key),
      .prev_lt (prev_lt),
      .next_key(next_key),
      .occupied(IDX < count),
      .key     (keys[i]),
      .lt      (lts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ERR_OK;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      err   <= err_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign top_ext      = 64'(keys[0]);
  assign rsp.valid    = rsp_valid;
  assign rsp.top_key  = empty ? '0 : top_ext[TOP_W-1:0];
  assign rsp.count    = COUNT_W'(count);
  assign rsp.is_empty = empty;
  assign rsp.error    = err;

  `SMPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_CNT)
  `SMPQ_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp.ready, !req.ready)
  `SMPQ_ASSERT_NEXT(a_push_grows, ctl.push, count == $past(count) + 1'b1)
  `SMPQ_ASSERT_NEXT(a_full_drop, accept && req.cmd == CMD_PUSH && full, err == ERR_FULL && $stable(count))
  if (CAPACITY > 1) begin : g_order_check
    `SMPQ_ASSERT_NOW(a_head_order, count >= CNT_W'(2), keys[0] <= keys[1])
  end

endmodule

>>> hdl/smpq_cell.sv
// ---------------------------------------------------------------------------
// Queue cell
// Holds one key, compares it with the pushed key and shifts with neighbors.
// ---------------------------------------------------------------------------
module smpq_cell import smpq_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  smpq_ctl_t            ctl,
  input  logic [KEY_WIDTH-1:0] push_key,
  input  logic [KEY_WIDTH-1:0] prev_key,
  input  logic                 prev_lt,
  input  logic [KEY_WIDTH-1:0] next_key,
  input  logic                 occupied,
  output logic [KEY_WIDTH-1:0] key,
  output logic                 lt
);

  logic [KEY_WIDTH-1:0] key_next;

  assign lt = occupied && (key < push_key);

  always_comb begin
    key_next = key;
    if (ctl.push) begin
      if (!lt) begin
        key_next = prev_lt ? push_key : prev_key;
      end
    end else if (ctl.pop) begin
      key_next = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule
